// ===== hw/rtl/rsort_pkg.sv =====
// ----------------------------------------------------------------------------
// rsort_pkg
// Shared constants, types and the digit select of the byte-wise radix sorter.
// ----------------------------------------------------------------------------
package rsort_pkg;

	localparam int KEY_W        = 64;
	localparam int DIGIT_W      = 8;
	localparam int BIN_COUNT    = 256;
	localparam int BIN_W        = 8;
	localparam int PASS_COUNT   = 8;
	localparam int PASS_W       = 3;
	localparam int MAX_KEYS_DEF = 64;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [BIN_W-1:0] bin_t;
	typedef logic [PASS_W-1:0] pass_t;

	function automatic bin_t digit_of(input key_t k, input pass_t p);
		return k[p * DIGIT_W +: DIGIT_W];
	endfunction

endpackage

// ===== hw/rtl/rsort_ram.sv =====
// ----------------------------------------------------------------------------
// rsort_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsort_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/rsort_pass.sv =====
// ----------------------------------------------------------------------------
// rsort_pass
// One stable counting-sort pass: histogram, running sum over 256 bins and
// backward scatter into the destination bank, all through one count table.
// ----------------------------------------------------------------------------
module rsort_pass #(
	parameter int MAX_KEYS = rsort_pkg::MAX_KEYS_DEF,
	localparam int ADDR_W = $clog2(MAX_KEYS),
	localparam int CNT_W  = $clog2(MAX_KEYS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  rsort_pkg::pass_t      pass_idx,
	input  logic [CNT_W-1:0]      key_count,
	output logic                  done,
	output logic                  src_rd_en,
	output logic [ADDR_W-1:0]     src_rd_addr,
	input  rsort_pkg::key_t       src_rd_data,
	output logic                  dst_wr_en,
	output logic [ADDR_W-1:0]     dst_wr_addr,
	output rsort_pkg::key_t       dst_wr_data
);

	import rsort_pkg::*;

	typedef enum logic [5:0] {
		P_IDLE = 6'b000001,
		P_H0   = 6'b000010,
		P_H1   = 6'b000100,
		P_SUM  = 6'b001000,
		P_S0   = 6'b010000,
		P_S1   = 6'b100000
	} pstate_t;

	pstate_t              state_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [BIN_W:0]       bin_q;
	logic [CNT_W-1:0]     sum_q;
	bin_t                 dig_q;
	key_t                 key_q;
	logic [BIN_COUNT-1:0] bin_valid_q;
	logic                 cnt_valid_q;

	logic                 cnt_wr_en;
	bin_t                 cnt_wr_addr;
	logic [CNT_W-1:0]     cnt_wr_data;
	logic                 cnt_rd_en;
	bin_t                 cnt_rd_addr;
	logic [CNT_W-1:0]     cnt_rd_data;
	logic [CNT_W-1:0]     cnt_val;
	bin_t                 dig;
	logic                 idx_last;
	logic [ADDR_W-1:0]    top_idx;

	rsort_ram #(
		.WIDTH(CNT_W),
		.DEPTH(BIN_COUNT)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (cnt_wr_en),
		.wr_addr (cnt_wr_addr),
		.wr_data (cnt_wr_data),
		.rd_en   (cnt_rd_en),
		.rd_addr (cnt_rd_addr),
		.rd_data (cnt_rd_data)
	);

	assign cnt_val  = cnt_valid_q ? cnt_rd_data : '0;
	assign dig      = digit_of(src_rd_data, pass_idx);
	assign idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == key_count;
	assign top_idx  = ADDR_W'(key_count - CNT_W'(1));
	assign done     = (state_q == P_S1) && (idx_q == '0);

	always_comb begin
		src_rd_en   = 1'b0;
		src_rd_addr = '0;
		dst_wr_en   = 1'b0;
		dst_wr_addr = '0;
		dst_wr_data = key_q;
		cnt_wr_en   = 1'b0;
		cnt_wr_addr = dig_q;
		cnt_wr_data = '0;
		cnt_rd_en   = 1'b0;
		cnt_rd_addr = dig;
		case (state_q)
			P_IDLE: begin
				src_rd_en = start;
			end
			P_H0: begin
				cnt_rd_en = 1'b1;
				if (!idx_last) begin
					src_rd_en   = 1'b1;
					src_rd_addr = idx_q + ADDR_W'(1);
				end
			end
			P_H1: begin
				cnt_wr_en   = 1'b1;
				cnt_wr_data = cnt_val + CNT_W'(1);
			end
			P_SUM: begin
				cnt_rd_en   = !bin_q[BIN_W];
				cnt_rd_addr = bin_q[BIN_W-1:0];
				if (bin_q != '0) begin
					cnt_wr_en   = 1'b1;
					cnt_wr_addr = BIN_W'(bin_q - (BIN_W+1)'(1));
					cnt_wr_data = sum_q + cnt_val;
				end
				if (bin_q[BIN_W]) begin
					src_rd_en   = 1'b1;
					src_rd_addr = top_idx;
				end
			end
			P_S0: begin
				cnt_rd_en = 1'b1;
				if (idx_q != '0) begin
					src_rd_en   = 1'b1;
					src_rd_addr = idx_q - ADDR_W'(1);
				end
			end
			P_S1: begin
				cnt_wr_en   = 1'b1;
				cnt_wr_data = cnt_val - CNT_W'(1);
				dst_wr_en   = 1'b1;
				dst_wr_addr = cnt_wr_data[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= P_IDLE;
			idx_q       <= '0;
			bin_q       <= '0;
			sum_q       <= '0;
			bin_valid_q <= '0;
			cnt_valid_q <= 1'b0;
		end else begin
			if (cnt_rd_en) begin
				cnt_valid_q <= bin_valid_q[cnt_rd_addr];
			end
			if (cnt_wr_en) begin
				bin_valid_q[cnt_wr_addr] <= 1'b1;
			end
			case (state_q)
				P_IDLE: begin
					if (start) begin
						bin_valid_q <= '0;
						idx_q       <= '0;
						state_q     <= P_H0;
					end
				end
				P_H0: begin
					state_q <= P_H1;
				end
				P_H1: begin
					if (idx_last) begin
						bin_q   <= '0;
						sum_q   <= '0;
						state_q <= P_SUM;
					end else begin
						idx_q   <= idx_q + ADDR_W'(1);
						state_q <= P_H0;
					end
				end
				P_SUM: begin
					if (bin_q != '0) begin
						sum_q <= cnt_wr_data;
					end
					if (bin_q[BIN_W]) begin
						idx_q   <= top_idx;
						state_q <= P_S0;
					end else begin
						bin_q <= bin_q + (BIN_W+1)'(1);
					end
				end
				P_S0: begin
					state_q <= P_S1;
				end
				P_S1: begin
					if (idx_q == '0) begin
						state_q <= P_IDLE;
					end else begin
						idx_q   <= idx_q - ADDR_W'(1);
						state_q <= P_S0;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == P_H0) || (state_q == P_S0)) begin
			dig_q <= dig;
			key_q <= src_rd_data;
		end
	end

endmodule

// ===== hw/rtl/radix_sort_u64_bytewise_core.sv =====
// Flow: keys are taken one per cycle while loading; after the key marked last, eight
//   passes of histogram, bin sum sweep and backward scatter, then keys stream out.
// Throughput is set by the count table update: a read and a write state per key in
//   histogram and scatter, one bin sum sweep per pass; input stalls until all are out.
// Reset: asynchronous, active low; clears the key count, drop flag and control state.
//   Key banks hold no reset; only entries written in the current set are read.
// ----------------------------------------------------------------------------
// radix_sort_u64_bytewise_core
// LSD radix sorter for 64-bit keys: loads a set, runs eight byte passes
// between two key banks and streams the keys out in ascending order.
// ----------------------------------------------------------------------------
module radix_sort_u64_bytewise_core #(
	parameter int MAX_KEYS = rsort_pkg::MAX_KEYS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rsort_pkg::key_t key,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_stall,
	output rsort_pkg::key_t sorted_key,
	output logic            last_out,
	output logic            overflow
);

	import rsort_pkg::*;

	localparam int ADDR_W = $clog2(MAX_KEYS);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);

	typedef enum logic [4:0] {
		T_LOAD  = 5'b00001,
		T_START = 5'b00010,
		T_RUN   = 5'b00100,
		T_DRD   = 5'b01000,
		T_DWAIT = 5'b10000
	} tstate_t;

	tstate_t           state_q;
	logic [CNT_W-1:0]  loaded_q;
	logic              dropped_q;
	pass_t             pass_q;
	logic [ADDR_W-1:0] out_idx_q;
	logic              out_valid_q;
	key_t              sorted_key_q;
	logic              last_out_q;
	logic              overflow_q;

	logic              in_acc;
	logic              full;
	logic              out_load;
	logic              out_final;

	logic              p_done;
	logic              p_rd_en;
	logic [ADDR_W-1:0] p_rd_addr;
	key_t              p_rd_data;
	logic              p_wr_en;
	logic [ADDR_W-1:0] p_wr_addr;
	key_t              p_wr_data;

	logic              a_wr_en;
	logic [ADDR_W-1:0] a_wr_addr;
	key_t              a_wr_data;
	logic              a_rd_en;
	logic [ADDR_W-1:0] a_rd_addr;
	key_t              a_rd_data;
	logic              b_wr_en;
	logic              b_rd_en;
	key_t              b_rd_data;

	assign in_stall  = (state_q != T_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign full      = (loaded_q == CNT_W'(MAX_KEYS));
	assign out_final = (CNT_W'(out_idx_q) + CNT_W'(1)) == loaded_q;
	assign out_load  = (state_q == T_DWAIT) && (!out_valid_q || !out_stall);

	assign a_wr_en   = (state_q == T_LOAD) ? (in_acc && !full) : (pass_q[0] && p_wr_en);
	assign a_wr_addr = (state_q == T_LOAD) ? loaded_q[ADDR_W-1:0] : p_wr_addr;
	assign a_wr_data = (state_q == T_LOAD) ? key : p_wr_data;
	assign a_rd_en   = (state_q == T_DRD) || (!pass_q[0] && p_rd_en);
	assign a_rd_addr = (state_q == T_DRD) ? out_idx_q : p_rd_addr;
	assign b_wr_en   = !pass_q[0] && p_wr_en;
	assign b_rd_en   = pass_q[0] && p_rd_en;
	assign p_rd_data = pass_q[0] ? b_rd_data : a_rd_data;

	rsort_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_KEYS)
	) u_bank_a (
		.clk     (clk),
		.wr_en   (a_wr_en),
		.wr_addr (a_wr_addr),
		.wr_data (a_wr_data),
		.rd_en   (a_rd_en),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data)
	);

	rsort_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_KEYS)
	) u_bank_b (
		.clk     (clk),
		.wr_en   (b_wr_en),
		.wr_addr (p_wr_addr),
		.wr_data (p_wr_data),
		.rd_en   (b_rd_en),
		.rd_addr (p_rd_addr),
		.rd_data (b_rd_data)
	);

	rsort_pass #(
		.MAX_KEYS(MAX_KEYS)
	) u_pass (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (state_q == T_START),
		.pass_idx    (pass_q),
		.key_count   (loaded_q),
		.done        (p_done),
		.src_rd_en   (p_rd_en),
		.src_rd_addr (p_rd_addr),
		.src_rd_data (p_rd_data),
		.dst_wr_en   (p_wr_en),
		.dst_wr_addr (p_wr_addr),
		.dst_wr_data (p_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_LOAD;
			loaded_q    <= '0;
			dropped_q   <= 1'b0;
			pass_q      <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_LOAD: begin
					if (in_acc) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							loaded_q <= loaded_q + CNT_W'(1);
						end
						if (last) begin
							pass_q  <= '0;
							state_q <= T_START;
						end
					end
				end
				T_START: begin
					state_q <= T_RUN;
				end
				T_RUN: begin
					if (p_done) begin
						if (pass_q == PASS_W'(PASS_COUNT - 1)) begin
							out_idx_q <= '0;
							state_q   <= T_DRD;
						end else begin
							pass_q  <= pass_q + PASS_W'(1);
							state_q <= T_START;
						end
					end
				end
				T_DRD: begin
					state_q <= T_DWAIT;
				end
				T_DWAIT: begin
					if (out_load) begin
						out_idx_q <= out_idx_q + ADDR_W'(1);
						if (out_final) begin
							loaded_q  <= '0;
							dropped_q <= 1'b0;
							state_q   <= T_LOAD;
						end else begin
							state_q <= T_DRD;
						end
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sorted_key_q <= a_rd_data;
			last_out_q   <= out_final;
			overflow_q   <= dropped_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sorted_key = sorted_key_q;
	assign last_out   = last_out_q;
	assign overflow   = overflow_q;

endmodule
